// File: rtl/ctcg_pkg.sv
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared widths, register indexes, result kinds and the command and status
// bundles that join the greedy decoder's controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctcg_pkg;

  // Field widths
  localparam int LOGIT_W     = 8;
  localparam int CLASS_CNT_W = 8;
  localparam int STEP_CNT_W  = 7;
  localparam int ZP_W        = 8;
  localparam int CLASS_IDX_W = 7;
  localparam int SYM_CNT_W   = 7;
  localparam int MEAN_W      = 17;
  localparam int MEAN_FRAC_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT  = 2'd2;

  localparam logic [CLASS_CNT_W-1:0] CLASS_COUNT_RST = 8'd97;
  localparam logic [STEP_CNT_W-1:0]  STEP_COUNT_RST  = 7'd40;
  localparam logic [ZP_W-1:0]        ZERO_POINT_RST  = 8'd0;

  // Result kinds
  localparam logic KIND_SYMBOL  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic div_step;  // advance the divider one quotient bit
    logic load_sum;  // load the summary word into the output register
  } ctcg_cmd_t;

  typedef struct packed {
    logic emit;      // the current word closes a step with a new symbol
    logic seq_end;   // the current word closes the sequence
    logic div_last;  // divider is on its final bit
  } ctcg_status_t;

endpackage

// File: rtl/ctc_greedy_decoder_core.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// Throughput: one logit word per cycle while no result word is pending or being computed.
// Symbol word: valid the cycle after the logit that closes its step.
// Summary word: valid once the bit-serial mean divider has run to its last bit
// and the quotient is loaded into the output register, plus any symbol hold.
// Reset clears all sequence state and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_greedy_decoder_core #(
  parameter int MAX_CLASSES = 128,
  parameter int MAX_STEPS   = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ctcg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ctcg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ctcg_pkg::LOGIT_W-1:0]  logit_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 kind_o,
  output logic [ctcg_pkg::CLASS_IDX_W-1:0]     class_index_o,
  output logic [ctcg_pkg::SYM_CNT_W-1:0]       symbol_count_o,
  output logic signed [ctcg_pkg::MEAN_W-1:0]   mean_score_o,
  output logic                                 last_o
);
  import ctcg_pkg::*;

  ctcg_cmd_t    cmd;
  ctcg_status_t status;

  ctcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ctcg_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .logit_i        (logit_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_o         (kind_o),
    .class_index_o  (class_index_o),
    .symbol_count_o (symbol_count_o),
    .mean_score_o   (mean_score_o),
    .last_o         (last_o)
  );

endmodule

// File: rtl/ctcg_div.sv
// ----------------------------------------------------------------------------
// ctcg_div
// Restoring divider, one quotient bit per cycle while step_i is high. Divides an unsigned
// magnitude and applies the sign afterwards, so the quotient truncates
// toward zero. A set zero_i flag (given for a zero divisor) yields a zero result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctcg_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [NUM_W-1:0]                 num_i,
  input  logic [DEN_W-1:0]                 den_i,
  input  logic                             neg_i,
  input  logic                             zero_i,
  input  logic                             step_i,
  output logic                             last_o,
  output logic signed [ctcg_pkg::MEAN_W-1:0] quot_o
);
  import ctcg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             zero_q, zero_d;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      diff;
  logic                fits;
  logic [MEAN_W-1:0]   q_mag;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      neg_d  = neg_i;
      zero_d = zero_i;
    end else if (step_i) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_d = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      zero_q <= 1'b1;
    end else begin
      num_q  <= num_d;
      den_q  <= den_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
      zero_q <= zero_d;
    end
  end

  assign last_o = cnt_q == CNT_W'(NUM_W - 1);
  assign q_mag  = num_q[MEAN_W-1:0];

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = signed'(-q_mag);
    end else begin
      quot_o = signed'(q_mag);
    end
  end

endmodule

// File: rtl/ctcg_datapath.sv
// ----------------------------------------------------------------------------
// ctcg_datapath
// Configuration registers, running argmax over one step, symbol collapse,
// score accumulation, the mean divider and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctcg_datapath #(
  parameter int MAX_CLASSES = 128,
  parameter int MAX_STEPS   = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ctcg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ctcg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [ctcg_pkg::LOGIT_W-1:0]  logit_i,
  input  ctcg_pkg::ctcg_cmd_t                  cmd_i,
  output ctcg_pkg::ctcg_status_t               status_o,
  output logic                                 kind_o,
  output logic [ctcg_pkg::CLASS_IDX_W-1:0]     class_index_o,
  output logic [ctcg_pkg::SYM_CNT_W-1:0]       symbol_count_o,
  output logic signed [ctcg_pkg::MEAN_W-1:0]   mean_score_o,
  output logic                                 last_o
);
  import ctcg_pkg::*;

  localparam int CW     = $clog2(MAX_CLASSES);
  localparam int CCMP_W = (CW + 1 > CLASS_CNT_W) ? CW + 1 : CLASS_CNT_W;
  localparam int SW     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SCMP_W = (SW + 1 > STEP_CNT_W) ? SW + 1 : STEP_CNT_W;
  localparam int EW     = $clog2(MAX_STEPS + 1);
  localparam int TERM_W = LOGIT_W + 1;
  localparam int SUM_W  = EW + TERM_W;
  localparam int NUM_W  = SUM_W + MEAN_FRAC_W;

  // Configuration
  logic [CLASS_CNT_W-1:0] class_count_q;
  logic [STEP_CNT_W-1:0]  step_count_q;
  logic signed [ZP_W-1:0] zero_point_q;

  // Sequence state
  logic [CW-1:0]             cls_cnt_q, cls_cnt_d;
  logic [SW-1:0]             stp_cnt_q, stp_cnt_d;
  logic signed [LOGIT_W-1:0] best_val_q, best_val_d;
  logic [CW-1:0]             best_cls_q, best_cls_d;
  logic [CW-1:0]             prev_cls_q, prev_cls_d;
  logic                      prev_valid_q, prev_valid_d;
  logic signed [SUM_W-1:0]   score_sum_q, score_sum_d;
  logic [EW-1:0]             emit_cnt_q, emit_cnt_d;
  logic [EW-1:0]             sum_cnt_q, sum_cnt_d;

  // Output word
  logic                      kind_q, kind_d;
  logic [CLASS_IDX_W-1:0]    cls_out_q, cls_out_d;
  logic [SYM_CNT_W-1:0]      sym_cnt_q, sym_cnt_d;
  logic signed [MEAN_W-1:0]  mean_q, mean_d;
  logic                      last_q, last_d;

  logic [CCMP_W-1:0]         cls_p1;
  logic [SCMP_W-1:0]         stp_p1;
  logic                      take;
  logic                      step_end;
  logic                      stp_last;
  logic                      seq_end;
  logic                      emit;
  logic signed [TERM_W-1:0]  term;
  logic signed [SUM_W-1:0]   sum_n;
  logic [EW-1:0]             emit_cnt_n;
  logic [SUM_W-1:0]          sum_abs;
  logic signed [MEAN_W-1:0]  div_quot;
  logic                      div_last;

  // A zero count acts as one: counter plus one always reaches it.
  assign cls_p1   = CCMP_W'(cls_cnt_q) + CCMP_W'(1);
  assign step_end = (cls_p1 >= CCMP_W'(class_count_q)) || (cls_p1 >= CCMP_W'(MAX_CLASSES));
  assign stp_p1   = SCMP_W'(stp_cnt_q) + SCMP_W'(1);
  assign stp_last = (stp_p1 >= SCMP_W'(step_count_q)) || (stp_p1 >= SCMP_W'(MAX_STEPS));
  assign seq_end  = step_end && stp_last;

  // First class of a step always loads; later ones only on a strict win.
  assign take       = (cls_cnt_q == '0) || (logit_i > best_val_q);
  assign best_val_d = take ? logit_i : best_val_q;
  assign best_cls_d = take ? cls_cnt_q : best_cls_q;

  assign emit = step_end && (best_cls_d != '0) &&
                (!prev_valid_q || (best_cls_d != prev_cls_q));

  assign term       = TERM_W'(best_val_d) - TERM_W'(zero_point_q);
  assign sum_n      = score_sum_q + (emit ? SUM_W'(term) : SUM_W'(0));
  assign emit_cnt_n = emit_cnt_q + EW'(emit);
  assign sum_abs    = sum_n[SUM_W-1] ? unsigned'(-sum_n) : unsigned'(sum_n);

  always_comb begin
    cls_cnt_d    = cls_cnt_q;
    stp_cnt_d    = stp_cnt_q;
    prev_cls_d   = prev_cls_q;
    prev_valid_d = prev_valid_q;
    score_sum_d  = score_sum_q;
    emit_cnt_d   = emit_cnt_q;
    sum_cnt_d    = sum_cnt_q;
    if (cmd_i.accept) begin
      if (!step_end) begin
        cls_cnt_d = cls_cnt_q + CW'(1);
      end else if (seq_end) begin
        // close the sequence: hand count and sum to the divider, clear the rest
        cls_cnt_d    = '0;
        stp_cnt_d    = '0;
        prev_cls_d   = '0;
        prev_valid_d = 1'b0;
        score_sum_d  = '0;
        emit_cnt_d   = '0;
        sum_cnt_d    = emit_cnt_n;
      end else begin
        cls_cnt_d    = '0;
        stp_cnt_d    = stp_cnt_q + SW'(1);
        prev_cls_d   = best_cls_d;
        prev_valid_d = 1'b1;
        score_sum_d  = sum_n;
        emit_cnt_d   = emit_cnt_n;
      end
    end
  end

  always_comb begin
    kind_d    = kind_q;
    cls_out_d = cls_out_q;
    sym_cnt_d = sym_cnt_q;
    mean_d    = mean_q;
    last_d    = last_q;
    if (cmd_i.accept && emit) begin
      kind_d    = KIND_SYMBOL;
      cls_out_d = CLASS_IDX_W'(best_cls_d);
      sym_cnt_d = '0;
      mean_d    = '0;
      last_d    = 1'b0;
    end else if (cmd_i.load_sum) begin
      kind_d    = KIND_SUMMARY;
      cls_out_d = '0;
      sym_cnt_d = SYM_CNT_W'(sum_cnt_q);
      mean_d    = div_quot;
      last_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      step_count_q  <= STEP_COUNT_RST;
      zero_point_q  <= signed'(ZERO_POINT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLASS_COUNT: class_count_q <= cfg_data_i[CLASS_CNT_W-1:0];
        REG_STEP_COUNT:  step_count_q  <= cfg_data_i[STEP_CNT_W-1:0];
        REG_ZERO_POINT:  zero_point_q  <= signed'(cfg_data_i[ZP_W-1:0]);
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_cnt_q    <= '0;
      stp_cnt_q    <= '0;
      best_val_q   <= '0;
      best_cls_q   <= '0;
      prev_cls_q   <= '0;
      prev_valid_q <= 1'b0;
      score_sum_q  <= '0;
      emit_cnt_q   <= '0;
      sum_cnt_q    <= '0;
    end else begin
      cls_cnt_q    <= cls_cnt_d;
      stp_cnt_q    <= stp_cnt_d;
      prev_cls_q   <= prev_cls_d;
      prev_valid_q <= prev_valid_d;
      score_sum_q  <= score_sum_d;
      emit_cnt_q   <= emit_cnt_d;
      sum_cnt_q    <= sum_cnt_d;
      if (cmd_i.accept) begin
        best_val_q <= best_val_d;
        best_cls_q <= best_cls_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    cls_out_q <= cls_out_d;
    sym_cnt_q <= sym_cnt_d;
    mean_q    <= mean_d;
    last_q    <= last_d;
  end

  ctcg_div #(
    .NUM_W (NUM_W),
    .DEN_W (EW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept && seq_end),
    .num_i   ({sum_abs, {MEAN_FRAC_W{1'b0}}}),
    .den_i   (emit_cnt_n),
    .neg_i   (sum_n[SUM_W-1]),
    .zero_i  (emit_cnt_n == '0),
    .step_i  (cmd_i.div_step),
    .last_o  (div_last),
    .quot_o  (div_quot)
  );

  assign status_o.emit     = emit;
  assign status_o.seq_end  = seq_end;
  assign status_o.div_last = div_last;

  assign kind_o         = kind_q;
  assign class_index_o  = cls_out_q;
  assign symbol_count_o = sym_cnt_q;
  assign mean_score_o   = mean_q;
  assign last_o         = last_q;

endmodule

// File: rtl/ctcg_ctrl.sv
// ----------------------------------------------------------------------------
// ctcg_ctrl
// Sequencer for the greedy decoder: takes words, holds each result word
// until the consumer takes it, and steps the divider at sequence end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctcg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  ctcg_pkg::ctcg_status_t status_i,
  output ctcg_pkg::ctcg_cmd_t    cmd_o
);
  import ctcg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SYM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_SUM  = 5'b10000
  } ctcg_state_e;

  ctcg_state_e state_q, state_d;
  logic        pend_q, pend_d;

  always_comb begin
    state_d         = state_q;
    pend_d          = pend_q;
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.div_step  = 1'b0;
    cmd_o.load_sum  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.emit) begin
            // symbol first, summary after it if this word also ends the sequence
            pend_d  = status_i.seq_end;
            state_d = ST_SYM;
          end else if (status_i.seq_end) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_SYM: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          pend_d  = 1'b0;
          state_d = pend_q ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.load_sum = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule
